FILE: design/sc2asc_pkg.sv
// ----------------------------------------------------------------------------
// sc2asc_pkg
// Shared constants, field widths and character tables for the set-1 scancode
// to ASCII translator.
// ----------------------------------------------------------------------------
package sc2asc_pkg;

    // Field widths
    localparam int unsigned ScanW   = 8;
    localparam int unsigned CodeW   = 7;
    localparam int unsigned AsciiW  = 7;
    localparam int unsigned EventW  = CodeW + 1 + 1 + AsciiW + 4;
    localparam int unsigned OutW    = ((EventW + 7) / 8) * 8;

    // Special bytes and codes
    localparam logic [ScanW-1:0] PfxExt0   = 8'hE0;
    localparam logic [ScanW-1:0] PfxExt1   = 8'hE1;
    localparam logic [CodeW-1:0] ScLShift  = 7'h2A;
    localparam logic [CodeW-1:0] ScRShift  = 7'h36;
    localparam logic [CodeW-1:0] ScCaps    = 7'h3A;
    localparam logic [CodeW-1:0] ScCtrl    = 7'h1D;
    localparam logic [CodeW-1:0] ScAlt     = 7'h38;
    localparam logic [CodeW-1:0] CodeMask  = 7'h7F;
    localparam int unsigned      RelBit    = 7;

    // One translated key event
    typedef struct packed {
        logic              caps_on;
        logic              alt_held;
        logic              ctrl_held;
        logic              shift_held;
        logic [AsciiW-1:0] ascii;
        logic              extended;
        logic              pressed;
        logic [CodeW-1:0]  key_code;
    } t_key_event;

    // Unshifted character table, codes 0 to 57; others give 0
    function automatic logic [AsciiW-1:0] rom_plain(input logic [CodeW-1:0] code);
        logic [AsciiW-1:0] c;
        case (code)
            7'd1:  c = 7'h1B;  7'd2:  c = 7'h31;  7'd3:  c = 7'h32;  7'd4:  c = 7'h33;
            7'd5:  c = 7'h34;  7'd6:  c = 7'h35;  7'd7:  c = 7'h36;  7'd8:  c = 7'h37;
            7'd9:  c = 7'h38;  7'd10: c = 7'h39;  7'd11: c = 7'h30;  7'd12: c = 7'h2D;
            7'd13: c = 7'h3D;  7'd14: c = 7'h08;  7'd15: c = 7'h09;  7'd16: c = 7'h71;
            7'd17: c = 7'h77;  7'd18: c = 7'h65;  7'd19: c = 7'h72;  7'd20: c = 7'h74;
            7'd21: c = 7'h79;  7'd22: c = 7'h75;  7'd23: c = 7'h69;  7'd24: c = 7'h6F;
            7'd25: c = 7'h70;  7'd26: c = 7'h5B;  7'd27: c = 7'h5D;  7'd28: c = 7'h0A;
            7'd30: c = 7'h61;  7'd31: c = 7'h73;  7'd32: c = 7'h64;  7'd33: c = 7'h66;
            7'd34: c = 7'h67;  7'd35: c = 7'h68;  7'd36: c = 7'h6A;  7'd37: c = 7'h6B;
            7'd38: c = 7'h6C;  7'd39: c = 7'h3B;  7'd40: c = 7'h27;  7'd41: c = 7'h60;
            7'd43: c = 7'h5C;  7'd44: c = 7'h7A;  7'd45: c = 7'h78;  7'd46: c = 7'h63;
            7'd47: c = 7'h76;  7'd48: c = 7'h62;  7'd49: c = 7'h6E;  7'd50: c = 7'h6D;
            7'd51: c = 7'h2C;  7'd52: c = 7'h2E;  7'd53: c = 7'h2F;  7'd55: c = 7'h2A;
            7'd57: c = 7'h20;
            default: c = '0;
        endcase
        return c;
    endfunction

    // Shifted character table, codes 0 to 57; others give 0
    function automatic logic [AsciiW-1:0] rom_shift(input logic [CodeW-1:0] code);
        logic [AsciiW-1:0] c;
        case (code)
            7'd1:  c = 7'h1B;  7'd2:  c = 7'h21;  7'd3:  c = 7'h40;  7'd4:  c = 7'h23;
            7'd5:  c = 7'h24;  7'd6:  c = 7'h25;  7'd7:  c = 7'h5E;  7'd8:  c = 7'h26;
            7'd9:  c = 7'h2A;  7'd10: c = 7'h28;  7'd11: c = 7'h29;  7'd12: c = 7'h5F;
            7'd13: c = 7'h2B;  7'd14: c = 7'h08;  7'd15: c = 7'h09;  7'd16: c = 7'h51;
            7'd17: c = 7'h57;  7'd18: c = 7'h45;  7'd19: c = 7'h52;  7'd20: c = 7'h54;
            7'd21: c = 7'h59;  7'd22: c = 7'h55;  7'd23: c = 7'h49;  7'd24: c = 7'h4F;
            7'd25: c = 7'h50;  7'd26: c = 7'h7B;  7'd27: c = 7'h7D;  7'd28: c = 7'h0A;
            7'd30: c = 7'h41;  7'd31: c = 7'h53;  7'd32: c = 7'h44;  7'd33: c = 7'h46;
            7'd34: c = 7'h47;  7'd35: c = 7'h48;  7'd36: c = 7'h4A;  7'd37: c = 7'h4B;
            7'd38: c = 7'h4C;  7'd39: c = 7'h3A;  7'd40: c = 7'h22;  7'd41: c = 7'h7E;
            7'd43: c = 7'h7C;  7'd44: c = 7'h5A;  7'd45: c = 7'h58;  7'd46: c = 7'h43;
            7'd47: c = 7'h56;  7'd48: c = 7'h42;  7'd49: c = 7'h4E;  7'd50: c = 7'h4D;
            7'd51: c = 7'h3C;  7'd52: c = 7'h3E;  7'd53: c = 7'h3F;  7'd55: c = 7'h2A;
            7'd57: c = 7'h20;
            default: c = '0;
        endcase
        return c;
    endfunction

    // True for 'a'..'z'
    function automatic logic is_lower(input logic [AsciiW-1:0] c);
        return (c >= 7'h61) && (c <= 7'h7A);
    endfunction

    // True for 'A'..'Z'
    function automatic logic is_upper(input logic [AsciiW-1:0] c);
        return (c >= 7'h41) && (c <= 7'h5A);
    endfunction

endpackage

FILE: design/scancode_to_ascii_translator.sv
// ----------------------------------------------------------------------------
// scancode_to_ascii_translator
// Turns set-1 scancode bytes into key events with modifier state and ASCII.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata fields (lowest bit first)
//  s        | in  | scan_byte[7:0]
//  m        | out | key_code[6:0], pressed, extended, ascii[6:0], shift_held,
//           |     | ctrl_held, alt_held, caps_on, zero pad to 24 bits
//
//  One byte per cycle sustained while the output is not stalled; a byte is held
//  in the input register, then its event is written to the result register.
//  Prefix bytes E0/E1 retire from the input register without a result.
//  Synchronous active-low reset clears flags and both valid bits.
//  Output stall holds the result word; the input register keeps taking bytes
//  until both registers are full.
// ----------------------------------------------------------------------------
module scancode_to_ascii_translator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [sc2asc_pkg::ScanW-1:0]  i_s_tdata,   // scan_byte[7:0]
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // key_code[6:0], pressed, extended, ascii[6:0], shift_held, ctrl_held,
    // alt_held, caps_on, zero pad
    output logic [sc2asc_pkg::OutW-1:0]   o_m_tdata
);
    import sc2asc_pkg::*;

    logic             r_in_valid;
    logic [ScanW-1:0] r_in_byte;
    logic             r_out_valid;
    t_key_event       r_out_event;

    logic r_shift, r_ctrl, r_alt, r_caps, r_prefix;
    logic n_shift, n_ctrl, n_alt, n_caps;

    logic              in_take;
    logic              in_move;
    logic              out_free;
    logic              is_prefix;
    logic              pressed;
    logic [CodeW-1:0]  code;
    logic [AsciiW-1:0] rom_char;
    logic [AsciiW-1:0] case_char;
    logic [AsciiW-1:0] n_ascii;
    t_key_event        n_event;

    // Handshake between stages
    assign out_free   = !r_out_valid || i_m_tready;
    assign is_prefix  = (r_in_byte == PfxExt0) || (r_in_byte == PfxExt1);
    assign in_move    = r_in_valid && (is_prefix || out_free);
    assign o_s_tready = !r_in_valid || in_move;
    assign in_take    = i_s_tvalid && o_s_tready;

    // Decode the held word
    assign code    = r_in_byte[CodeW-1:0] & CodeMask;
    assign pressed = !r_in_byte[RelBit];

    // Look up, apply caps inversion, then ctrl letter mapping
    always_comb begin
        rom_char  = r_shift ? rom_shift(code) : rom_plain(code);
        case_char = rom_char;
        if (r_caps && (is_lower(rom_char) || is_upper(rom_char))) begin
            case_char = rom_char ^ 7'h20;
        end
        n_ascii = case_char;
        if (r_ctrl && (is_lower(case_char) || is_upper(case_char))) begin
            n_ascii = {2'b00, case_char[4:0]};
        end
    end

    // Update modifier flags and build the event
    always_comb begin
        n_shift = r_shift;
        n_ctrl  = r_ctrl;
        n_alt   = r_alt;
        n_caps  = r_caps;
        n_event = '0;
        n_event.key_code = code;
        n_event.pressed  = pressed;
        n_event.extended = r_prefix;
        if (!pressed) begin
            if (code == ScLShift || code == ScRShift) begin
                n_shift = 1'b0;
            end else if (code == ScCtrl) begin
                n_ctrl = 1'b0;
            end else if (code == ScAlt) begin
                n_alt = 1'b0;
            end
        end else if (code == ScLShift || code == ScRShift) begin
            n_shift = 1'b1;
        end else if (code == ScCaps) begin
            n_caps = !r_caps;
        end else if (code == ScCtrl) begin
            n_ctrl = 1'b1;
        end else if (code == ScAlt) begin
            n_alt = 1'b1;
        end else begin
            n_event.ascii = n_ascii;
        end
        n_event.shift_held = n_shift;
        n_event.ctrl_held  = n_ctrl;
        n_event.alt_held   = n_alt;
        n_event.caps_on    = n_caps;
    end

    // Input register, flags and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_shift     <= 1'b0;
            r_ctrl      <= 1'b0;
            r_alt       <= 1'b0;
            r_caps      <= 1'b0;
            r_prefix    <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (in_move) begin
                r_in_valid <= 1'b0;
            end
            if (in_move && !is_prefix) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (in_move) begin
                if (is_prefix) begin
                    r_prefix <= 1'b1;
                end else begin
                    r_prefix <= 1'b0;
                    r_shift  <= n_shift;
                    r_ctrl   <= n_ctrl;
                    r_alt    <= n_alt;
                    r_caps   <= n_caps;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_s_tdata;
        end
        if (in_move && !is_prefix) begin
            r_out_event <= n_event;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OutW'(r_out_event);

endmodule

FILE: design/sc2asc_checker.sv
// ----------------------------------------------------------------------------
// sc2asc_checker
// Port-level checks on the translator's result channel, bound to the top.
// ----------------------------------------------------------------------------
module sc2asc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [sc2asc_pkg::OutW-1:0]   o_m_tdata
);
    import sc2asc_pkg::*;

    t_key_event ev;
    assign ev = o_m_tdata[EventW-1:0];

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // Hold a stalled word
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled word changed");

    // Shift make words carry no character and show shift held
    a_shift_make: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && ev.pressed && (ev.key_code == ScLShift || ev.key_code == ScRShift)
        |-> ev.shift_held && (ev.ascii == '0))
        else $error("shift make word wrong");

    // No letter passes while ctrl is held; letters become control codes
    a_ctrl_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && ev.ctrl_held |-> !is_lower(ev.ascii) && !is_upper(ev.ascii))
        else $error("letter passed with ctrl held");

endmodule

bind scancode_to_ascii_translator sc2asc_checker u_sc2asc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
